@@ rtl/chtab_pkg.sv @@
package chtab_pkg;

  localparam int BUCKETS    = 8;
  localparam int POOL_NODES = 64;
  localparam int VALUE_BITS = 64;

  localparam int REQ_W  = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W  = $clog2(POOL_NODES);
  localparam int NODE_W = $clog2(POOL_NODES + 1);

  localparam logic [NODE_W-1:0] NIL = NODE_W'(POOL_NODES);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_WALK,
    S_UNL_PREV,
    S_UNL_FREE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              walk_step;
    logic              ins;
    logic              unl_prev;
    logic              unl_free;
    logic              resp_load;
    logic [STAT_W-1:0] resp_code;
    logic              resp_found;
  } cmd_t;

  typedef struct packed {
    logic head_nil;
    logic pool_full;
    logic hit;
    logic walk_end;
    logic out_busy;
  } sts_t;

  function automatic logic [NODE_W-1:0] link_ok(input logic [NODE_W-1:0] x);
    return (x < NIL) ? x : NIL;
  endfunction

  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] k);
    return BKT_W'(k % KEY_W'(BUCKETS));
  endfunction

endpackage

@@ rtl/chtab_if.sv @@
interface chtab_in_if import chtab_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface chtab_out_if import chtab_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

@@ rtl/chtab_ram.sv @@
module chtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/chtab_datapath.sv @@
module chtab_datapath import chtab_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [VAL_W-1:0]  out_found_value
);

  logic [NODE_W-1:0]     head_r [BUCKETS];
  logic [NODE_W-1:0]     free_head_r;
  logic [NODE_W-1:0]     unused_r;
  logic                  out_valid_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BKT_W-1:0]      bkt_r;
  logic [NODE_W-1:0]     p_r;
  logic [NODE_W-1:0]     q_r;
  logic [NODE_W-1:0]     steps_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [VAL_W-1:0]      out_found_r;

  logic [BKT_W-1:0]      in_bkt;
  logic [NODE_W-1:0]     p0;
  logic [NODE_W-1:0]     np;
  logic                  free_nil;
  logic [IDX_W-1:0]      node_idx;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [KEY_W-1:0]      key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [NODE_W-1:0]     next_rd;
  logic                  next_we;
  logic [IDX_W-1:0]      next_wa;
  logic [NODE_W-1:0]     next_wd;

  assign in_bkt   = bucket_of(in_key);
  assign p0       = link_ok(head_r[in_bkt]);
  assign np       = link_ok(next_rd);
  assign free_nil = (free_head_r == NIL);
  assign node_idx = free_nil ? unused_r[IDX_W-1:0] : free_head_r[IDX_W-1:0];

  assign sts.head_nil  = (p0 == NIL);
  assign sts.pool_full = free_nil && (unused_r == NODE_W'(POOL_NODES));
  assign sts.hit       = (key_rd == key_r);
  assign sts.walk_end  = (np == NIL) || (steps_r == NODE_W'(POOL_NODES - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  // one shared read address: free-list pop, chain head, or next hop
  assign rd_en = cmd.accept || cmd.walk_step;
  always_comb begin
    if (cmd.accept) begin
      rd_addr = (in_req_type == REQ_INSERT) ? free_head_r[IDX_W-1:0] : p0[IDX_W-1:0];
    end else begin
      rd_addr = np[IDX_W-1:0];
    end
  end

  always_comb begin
    next_we = 1'b0;
    next_wa = node_idx;
    next_wd = link_ok(head_r[bkt_r]);
    if (cmd.ins) begin
      next_we = 1'b1;
    end else if (cmd.unl_prev) begin
      next_we = (q_r != NIL);
      next_wa = q_r[IDX_W-1:0];
      next_wd = np;
    end else if (cmd.unl_free) begin
      next_we = 1'b1;
      next_wa = p_r[IDX_W-1:0];
      next_wd = free_head_r;
    end
  end

  chtab_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_key_ram (
    .clk     (clk),
    .wr_en   (cmd.ins),
    .wr_addr (node_idx),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  chtab_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_val_ram (
    .clk     (clk),
    .wr_en   (cmd.ins),
    .wr_addr (node_idx),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (val_rd)
  );

  chtab_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_next_ram (
    .clk     (clk),
    .wr_en   (next_we),
    .wr_addr (next_wa),
    .wr_data (next_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (next_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) begin
        head_r[i] <= NIL;
      end
      free_head_r <= NIL;
      unused_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins) begin
        head_r[bkt_r] <= NODE_W'(node_idx);
        if (free_nil) begin
          unused_r <= unused_r + NODE_W'(1);
        end else begin
          free_head_r <= np;
        end
      end
      if (cmd.unl_prev && (q_r == NIL)) begin
        head_r[bkt_r] <= np;
      end
      if (cmd.unl_free) begin
        free_head_r <= p_r;
      end
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r   <= in_key;
      val_r   <= in_value[VALUE_BITS-1:0];
      bkt_r   <= in_bkt;
      p_r     <= p0;
      q_r     <= NIL;
      steps_r <= '0;
    end else if (cmd.walk_step) begin
      q_r     <= p_r;
      p_r     <= np;
      steps_r <= steps_r + NODE_W'(1);
    end
    if (cmd.resp_load) begin
      out_status_r <= cmd.resp_code;
      out_found_r  <= cmd.resp_found ? VAL_W'(val_rd) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;

endmodule

@@ rtl/chtab_ctrl.sv @@
module chtab_ctrl import chtab_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req_type,
  output logic             in_ready,
  input  sts_t             sts,
  output cmd_t             cmd
);

  state_t            state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [STAT_W-1:0] code_r, code_nxt;
  logic              found_r, found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      req_r   <= REQ_INSERT;
      code_r  <= STAT_OK;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
      code_r  <= code_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    code_nxt       = code_r;
    found_nxt      = found_r;
    cmd            = '0;
    cmd.resp_code  = code_r;
    cmd.resp_found = found_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          req_nxt    = in_req_type;
          code_nxt   = STAT_OK;
          found_nxt  = 1'b0;
          case (in_req_type) inside
            REQ_INSERT: begin
              if (sts.pool_full) begin
                code_nxt  = STAT_FULL;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_INS;
              end
            end
            REQ_DELETE, REQ_SEARCH: begin
              if (sts.head_nil) begin
                code_nxt  = STAT_MISS;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_RESP;
      end
      S_WALK: begin
        if (sts.hit) begin
          if (req_r == REQ_DELETE) begin
            state_nxt = S_UNL_PREV;
          end else begin
            found_nxt = 1'b1;
            state_nxt = S_RESP;
          end
        end else if (sts.walk_end) begin
          code_nxt  = STAT_MISS;
          state_nxt = S_RESP;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_UNL_PREV: begin
        cmd.unl_prev = 1'b1;
        state_nxt    = S_UNL_FREE;
      end
      S_UNL_FREE: begin
        cmd.unl_free = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/chained_hash_table.sv @@
// Channel  Dir  Payload                              Word accepted at
// in_chan  in   req_type[1:0] key[30:0] value[63:0]  valid && ready
// out_chan out  status[1:0] found_value[63:0]        valid && ready
//
// Insert: S_INS then S_RESP (S_RESP alone when the pool is full).
// Search/delete: S_WALK visits one node per cycle through the shared node
// RAM read port, then S_RESP; a delete hit adds S_UNL_PREV, S_UNL_FREE.
// Reset: bucket heads and free list come up empty; no clearing pass.
// The result register frees the engine: a word is accepted while a result
// waits; a stalled out_chan holds the engine only in its response step.
module chained_hash_table import chtab_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  chtab_in_if.sink   in_chan,
  chtab_out_if.source out_chan
);

  cmd_t cmd;
  sts_t sts;

  chtab_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  chtab_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_chan.req_type),
    .in_key          (in_chan.key),
    .in_value        (in_chan.value),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_found_value (out_chan.found_value)
  );

endmodule

@@ bench/chtab_checker.sv @@
module chtab_checker import chtab_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  chtab_in_if  in_chan,
  chtab_out_if out_chan,
  output int   fail_count,
  output int   pending
);

  localparam logic [VAL_W-1:0] VAL_MASK = (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}} :
                                          (VAL_W'(1) << VALUE_BITS) - VAL_W'(1);

  typedef struct packed {
    stat_t            status;
    logic [VAL_W-1:0] found_value;
  } answer_t;

  logic [NODE_W-1:0] head  [BUCKETS];
  logic [KEY_W-1:0]  nkey  [POOL_NODES];
  logic [VAL_W-1:0]  nval  [POOL_NODES];
  logic [NODE_W-1:0] nnext [POOL_NODES];
  logic [NODE_W-1:0] free_list;
  int                fresh_used;
  answer_t           answers_due[$];
  int                errors = 0;
  int                seen = 0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("mismatch: %s", what);
  endtask

  function automatic void clear_table();
    for (int b = 0; b < BUCKETS; b++) head[b] = NIL;
    free_list  = NIL;
    fresh_used = 0;
  endfunction

  // first node holding k in bucket b; prv is the node ahead of it
  function automatic logic [NODE_W-1:0] lookup(input logic [BKT_W-1:0] b,
                                               input logic [KEY_W-1:0] k,
                                               output logic [NODE_W-1:0] prv);
    logic [NODE_W-1:0] cur;
    int                hops;
    cur  = head[b];
    prv  = NIL;
    hops = 0;
    while (cur != NIL && hops < POOL_NODES) begin
      if (nkey[cur] == k) return cur;
      prv = cur;
      cur = nnext[cur];
      hops++;
    end
    return NIL;
  endfunction

  function automatic answer_t run_request(input logic [REQ_W-1:0] rq,
                                          input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v);
    answer_t           ans;
    logic [BKT_W-1:0]  b;
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] prv;
    ans.status      = STAT_OK;
    ans.found_value = '0;
    b = BKT_W'(k % BUCKETS);
    case (rq)
      REQ_INSERT: begin
        n = NIL;
        if (free_list != NIL) begin
          n         = free_list;
          free_list = nnext[n];
        end else if (fresh_used < POOL_NODES) begin
          n = NODE_W'(fresh_used);
          fresh_used++;
        end
        if (n == NIL) begin
          ans.status = STAT_FULL;
        end else begin
          nkey[n]  = k;
          nval[n]  = v & VAL_MASK;
          nnext[n] = head[b];
          head[b]  = n;
        end
      end
      REQ_DELETE: begin
        n = lookup(b, k, prv);
        if (n == NIL) begin
          ans.status = STAT_MISS;
        end else begin
          if (prv == NIL) head[b] = nnext[n];
          else nnext[prv] = nnext[n];
          nnext[n]  = free_list;
          free_list = n;
        end
      end
      REQ_SEARCH: begin
        n = lookup(b, k, prv);
        if (n == NIL) ans.status = STAT_MISS;
        else ans.found_value = nval[n];
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      clear_table();
      answers_due.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        seen++;
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing outstanding", seen));
        end else begin
          want = answers_due.pop_front();
          if (out_chan.status !== want.status)
            report_mismatch($sformatf("word %0d: got status %0d, want %0d",
                                      seen, out_chan.status, want.status));
          if (out_chan.found_value !== want.found_value)
            report_mismatch($sformatf("word %0d: got found_value %h, want %h",
                                      seen, out_chan.found_value, want.found_value));
        end
      end
      if (in_chan.valid && in_chan.ready)
        answers_due.push_back(run_request(in_chan.req_type, in_chan.key, in_chan.value));
    end
    fail_count <= errors;
    pending    <= answers_due.size();
  end

endmodule

@@ bench/tb_chained_hash_table.sv @@
module tb_chained_hash_table;
  import chtab_pkg::*;

  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
  localparam int LIMIT        = 1_000_000;
  localparam int RANDOM_ITEMS = 1150;

  logic             clk = 1'b0;
  logic             rst_n;
  int               fail_count;
  int               pending;
  int               cycles = 0;
  bit               quiet;
  logic [KEY_W-1:0] key_set [32];

  chtab_in_if  in_chan ();
  chtab_out_if out_chan ();

  chained_hash_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  chtab_checker shadow (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input int lane);
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom);
    else k = key_set[$urandom_range(0, 31)];
    if (lane >= 0) k = k - KEY_W'(k % BUCKETS) + KEY_W'(lane);
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(input logic [REQ_W-1:0] rq, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= rq;
    in_chan.key      <= k;
    in_chan.value    <= v;
    do @(posedge clk); while (!in_chan.ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // lane >= 0 forces every key into that bucket
  task automatic run_phase(input int count, input int w_ins, input int w_del,
                           input int w_find, input int lane, input bit calm);
    int               r;
    logic [REQ_W-1:0] rq;
    quiet = calm;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) rq = REQ_INSERT;
      else if (r < w_ins + w_del) rq = REQ_DELETE;
      else if (r < w_ins + w_del + w_find) rq = REQ_SEARCH;
      else rq = REQ_IGNORED;
      send_word(rq, pick_key(lane), pick_value());
    end
  endtask

  initial begin
    int hold;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        hold = gap_len();
      end else begin
        out_chan.ready <= 1'b1;
        hold = $urandom_range(1, 30);
      end
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    int sent;
    int lane;
    int n;
    rst_n            <= 1'b0;
    quiet             = 1'b1;
    in_chan.valid    <= 1'b0;
    in_chan.req_type <= REQ_SEARCH;
    in_chan.key      <= '0;
    in_chan.value    <= '0;
    key_set[0] = '0;
    key_set[1] = '1;
    for (int i = 2; i < 32; i++) key_set[i] = KEY_W'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_word(REQ_SEARCH, 31'd0, '0);
    send_word(REQ_DELETE, 31'd0, '0);
    send_word(REQ_INSERT, 31'd0, 64'h0);
    send_word(REQ_INSERT, 31'd0, '1);
    send_word(REQ_SEARCH, 31'd0, '0);
    send_word(REQ_INSERT, 31'h7FFF_FFFF, 64'h8000_0000_0000_0001);
    send_word(REQ_SEARCH, 31'h7FFF_FFFF, '0);
    send_word(REQ_INSERT, 31'd8, 64'hA5A5_5A5A_0F0F_F0F0);
    send_word(REQ_DELETE, 31'd0, '0);       // unlinks a middle node
    send_word(REQ_SEARCH, 31'd0, '0);
    send_word(REQ_SEARCH, 31'd8, '0);
    send_word(REQ_DELETE, 31'd8, '0);       // head of chain
    send_word(REQ_DELETE, 31'd0, '0);
    send_word(REQ_SEARCH, 31'd0, '0);
    send_word(REQ_IGNORED, 31'd5, '1);
    send_word(REQ_SEARCH, 31'd5, '0);
    send_word(REQ_INSERT, 31'd16, 64'h0123_4567_89AB_CDEF);  // from free list
    send_word(REQ_SEARCH, 31'd16, '0);
    send_word(REQ_DELETE, 31'h7FFF_FFFF, '0);
    send_word(REQ_SEARCH, 31'h7FFF_FFFF, '0);
    send_word(REQ_INSERT, 31'h7FFF_FFFF, 64'h1);
    send_word(REQ_SEARCH, 31'h7FFF_FFF7, '0);

    // runs the pool dry, then drains it
    run_phase(90, 85, 5, 8, -1, 1'b0);
    run_phase(100, 10, 55, 33, -1, 1'b0);
    drain();
    // one long chain, full-length walks
    run_phase(130, 60, 12, 26, $urandom_range(0, BUCKETS - 1), 1'b0);
    sent = 320;
    while (sent < RANDOM_ITEMS) begin
      n    = $urandom_range(60, 120);
      lane = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, BUCKETS - 1)) : -1;
      case ($urandom_range(0, 3))
        0:       run_phase(n, 75, 8, 15, lane, $urandom_range(0, 3) == 0);
        1:       run_phase(n, 15, 50, 33, lane, $urandom_range(0, 3) == 0);
        2:       run_phase(n, 35, 30, 33, lane, $urandom_range(0, 3) == 0);
        default: run_phase(n, 30, 15, 53, lane, $urandom_range(0, 3) == 0);
      endcase
      sent += n;
      if ($urandom_range(0, 4) == 0) drain();
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
